[hw/rtl/rdft_pkg.sv]
// ----------------------------------------------------------------------------
// rdft_pkg
// Shared types, codes and constants of the running dft bin accumulator.
// ----------------------------------------------------------------------------
package rdft_pkg;

    // default sizes
    localparam int unsigned MAX_BINS_DEF         = 64;
    localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
    localparam int unsigned ACC_WIDTH_DEF        = 48;

    // fixed field widths
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned NF_W       = 6;
    localparam int unsigned BIN_IDX_W  = 6;
    localparam int unsigned SUM_W      = 48;
    localparam int unsigned TRIG_W     = 16;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // queue sizes
    localparam int unsigned ITEM_Q_DEPTH = 2;
    localparam int unsigned RES_Q_DEPTH  = 2;
    localparam int unsigned RES_CNT_W    = $clog2(RES_Q_DEPTH + 1);

    // pi/2 in unsigned q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCUM = 2'd0,
        CMD_DUMP  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_START    = 2'd0,
        REG_PHASE_STEP     = 2'd1,
        REG_FREQ_INTERVALS = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DUMP,
        ST_DRAIN
    } back_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_start;
        logic [PHASE_W-1:0] phase_step;
        logic [NF_W-1:0]    freq_intervals;
    } cfg_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]          time_index;
    } item_t;

    typedef struct packed {
        logic [BIN_IDX_W-1:0]    bin_index;
        logic [PHASE_W-1:0]      bin_phase;
        logic signed [SUM_W-1:0] sum_real;
        logic signed [SUM_W-1:0] sum_imag;
        logic                    last;
    } result_t;

endpackage

[hw/rtl/running_dft_bin_accumulator.sv]
// ----------------------------------------------------------------------------
// running_dft_bin_accumulator
// Running dft over evenly spaced bins with saturating complex accumulators,
// dump and clear commands.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    cmd, sample, time_index
// out      output     out_valid / out_stall  bin_index, bin_phase, sum_real, sum_imag, last
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// accumulate runs one bin per cycle through the phase multiply, sine table and
// accumulator ram read-modify-write, then the pipe drains.
// dump reads one bin from the accumulator ram per slot free in the two-entry
// result queue.
// reset leaves all sums reading zero at once through per-bin valid bits.
// out_stall backs up into the result queue, then the bin engine, then in_stall.
// ----------------------------------------------------------------------------
module running_dft_bin_accumulator #(
    parameter int unsigned MAX_BINS         = rdft_pkg::MAX_BINS_DEF,
    parameter int unsigned SINE_TABLE_DEPTH = rdft_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int unsigned ACC_WIDTH        = rdft_pkg::ACC_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [rdft_pkg::CMD_W-1:0]             cmd,
    input  logic signed [rdft_pkg::SAMPLE_W-1:0]   sample,
    input  logic [rdft_pkg::TIME_W-1:0]            time_index,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [rdft_pkg::BIN_IDX_W-1:0]         bin_index,
    output logic [rdft_pkg::PHASE_W-1:0]           bin_phase,
    output logic signed [rdft_pkg::SUM_W-1:0]      sum_real,
    output logic signed [rdft_pkg::SUM_W-1:0]      sum_imag,
    output logic                                   last,
    input  logic                                   cfg_we,
    input  logic [rdft_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rdft_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int unsigned NF_W  = rdft_pkg::NF_W;
    localparam int unsigned RES_W = $bits(rdft_pkg::result_t);

    rdft_pkg::cfg_t    cfg_reg, cfg_next;
    logic              item_valid, item_pop;
    rdft_pkg::item_t   item;
    logic              res_push, res_full, res_empty;
    rdft_pkg::result_t res;
    rdft_pkg::result_t res_head;
    logic [RES_W-1:0]  res_rdata;
    logic [rdft_pkg::RES_CNT_W-1:0] res_count;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rdft_pkg::REG_PHASE_START:    cfg_next.phase_start    = cfg_data;
                rdft_pkg::REG_PHASE_STEP:     cfg_next.phase_step     = cfg_data;
                rdft_pkg::REG_FREQ_INTERVALS: cfg_next.freq_intervals = cfg_data[NF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rdft_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .sample     (sample),
        .time_index (time_index),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    rdft_back #(
        .MAX_BINS         (MAX_BINS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ACC_WIDTH        (ACC_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_count  (res_count),
        .res_push   (res_push),
        .res        (res)
    );

    // result queue parts the bin engine from the output stall
    rdft_fifo #(
        .WIDTH (RES_W),
        .DEPTH (rdft_pkg::RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .pop   (out_valid && !out_stall),
        .rdata (res_rdata),
        .full  (res_full),
        .empty (res_empty),
        .count (res_count)
    );

    assign res_head  = rdft_pkg::result_t'(res_rdata);
    assign out_valid = !res_empty;
    assign bin_index = res_head.bin_index;
    assign bin_phase = res_head.bin_phase;
    assign sum_real  = res_head.sum_real;
    assign sum_imag  = res_head.sum_imag;
    assign last      = res_head.last;

    // dump reads are only issued with a result slot reserved
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // the bin engine only takes a queued transaction that is there
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid)
        else $error("item popped from an empty queue");

    // a stalled result transaction holds still
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(res_rdata)))
        else $error("result changed while stalled");

endmodule

[hw/rtl/rdft_ram.sv]
// ----------------------------------------------------------------------------
// rdft_ram
// Generic single write port ram with one registered read port.
// ----------------------------------------------------------------------------
module rdft_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[hw/rtl/rdft_fifo.sv]
// ----------------------------------------------------------------------------
// rdft_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module rdft_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

[hw/rtl/rdft_sine_rom.sv]
// ----------------------------------------------------------------------------
// rdft_sine_rom
// Quarter wave sine table with quadrant folding; registered sin and cos of a
// 32-bit cycle fraction in signed q15.
// ----------------------------------------------------------------------------
module rdft_sine_rom #(
    parameter int unsigned DEPTH = rdft_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic [rdft_pkg::PHASE_W-1:0]           phase,
    output logic signed [rdft_pkg::TRIG_W-1:0]     sin_q,
    output logic signed [rdft_pkg::TRIG_W-1:0]     cos_q
);

    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned Q_W     = ADDR_W - 2;
    localparam int unsigned QUARTER = DEPTH / 4;
    localparam int unsigned PHASE_W = rdft_pkg::PHASE_W;
    localparam int unsigned TRIG_W  = rdft_pkg::TRIG_W;

    // taylor series to x^13 in unsigned q30, rounded to q15
    function automatic logic [14:0] quarter_sine(input int unsigned r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rnd;
        x    = (rdft_pkg::HALF_PI_Q30 * 64'(r)) / QUARTER;
        x2   = (x * x) >> 30;
        term = x;
        acc  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        acc  = acc + signed'(term);
        if (acc < 0)
        begin
            acc = '0;
        end
        rnd = (64'(acc) + 64'd16384) >> 15;
        if (rnd > 64'd32767)
        begin
            rnd = 64'd32767;
        end
        return rnd[14:0];
    endfunction

    logic [14:0] qtab [QUARTER+1];

    genvar g;
    generate
        for (g = 0; g <= QUARTER; g++)
        begin : g_tab
            localparam logic [14:0] QVal = quarter_sine(g);
            assign qtab[g] = QVal;
        end
    endgenerate

    logic [ADDR_W-1:0]        k_sin, k_cos;
    logic [Q_W:0]             i_sin, i_cos;
    logic signed [TRIG_W-1:0] v_sin, v_cos;

    always_comb
    begin
        k_sin = phase[PHASE_W-1 -: ADDR_W];
        k_cos = ADDR_W'(k_sin + ADDR_W'(QUARTER));
        // odd quadrants run the quarter wave backwards
        i_sin = k_sin[ADDR_W-2] ? (Q_W+1)'((Q_W+1)'(QUARTER) - {1'b0, k_sin[Q_W-1:0]})
                                : {1'b0, k_sin[Q_W-1:0]};
        i_cos = k_cos[ADDR_W-2] ? (Q_W+1)'((Q_W+1)'(QUARTER) - {1'b0, k_cos[Q_W-1:0]})
                                : {1'b0, k_cos[Q_W-1:0]};
        // lower half wave is negative
        v_sin = k_sin[ADDR_W-1] ? -$signed({1'b0, qtab[i_sin]}) : $signed({1'b0, qtab[i_sin]});
        v_cos = k_cos[ADDR_W-1] ? -$signed({1'b0, qtab[i_cos]}) : $signed({1'b0, qtab[i_cos]});
    end

    always_ff @(posedge clk)
    begin
        sin_q <= v_sin;
        cos_q <= v_cos;
    end

endmodule

[hw/rtl/rdft_front.sv]
// ----------------------------------------------------------------------------
// rdft_front
// Input side: takes transactions, drops the reserved command and queues the
// rest for the bin engine.
// ----------------------------------------------------------------------------
module rdft_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rdft_pkg::CMD_W-1:0]           cmd,
    input  logic signed [rdft_pkg::SAMPLE_W-1:0] sample,
    input  logic [rdft_pkg::TIME_W-1:0]          time_index,
    output logic                                 item_valid,
    output rdft_pkg::item_t                      item,
    input  logic                                 item_pop
);

    localparam int unsigned ITEM_W = $bits(rdft_pkg::item_t);

    rdft_pkg::item_t   item_in;
    logic [ITEM_W-1:0] q_rdata;
    logic              q_full, q_empty;
    logic              known, push;

    always_comb
    begin
        unique case (cmd) inside
            rdft_pkg::CMD_ACCUM, rdft_pkg::CMD_DUMP, rdft_pkg::CMD_CLEAR: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    always_comb
    begin
        item_in.cmd        = rdft_pkg::cmd_t'(cmd);
        item_in.sample     = sample;
        item_in.time_index = time_index;
    end

    assign in_stall   = q_full;
    // reserved command is consumed with no effect
    assign push       = in_valid && !q_full && known;
    assign item_valid = !q_empty;
    assign item       = rdft_pkg::item_t'(q_rdata);

    rdft_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (rdft_pkg::ITEM_Q_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item_in),
        .pop   (item_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty),
        .count ()
    );

endmodule

[hw/rtl/rdft_back.sv]
// ----------------------------------------------------------------------------
// rdft_back
// Bin engine: walks the bins of one queued command, runs the phase multiply,
// sine lookup, sample products and saturating read-modify-write, and reads
// bins out for a dump.
// ----------------------------------------------------------------------------
module rdft_back #(
    parameter int unsigned MAX_BINS         = rdft_pkg::MAX_BINS_DEF,
    parameter int unsigned SINE_TABLE_DEPTH = rdft_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int unsigned ACC_WIDTH        = rdft_pkg::ACC_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rdft_pkg::cfg_t                    cfg,
    input  logic                              item_valid,
    input  rdft_pkg::item_t                   item,
    output logic                              item_pop,
    input  logic [rdft_pkg::RES_CNT_W-1:0]    res_count,
    output logic                              res_push,
    output rdft_pkg::result_t                 res
);

    localparam int unsigned BIN_W       = $clog2(MAX_BINS);
    localparam int unsigned NF_W        = rdft_pkg::NF_W;
    localparam int unsigned PHASE_W     = rdft_pkg::PHASE_W;
    localparam int unsigned SAMPLE_W    = rdft_pkg::SAMPLE_W;
    localparam int unsigned TIME_W      = rdft_pkg::TIME_W;
    localparam int unsigned TRIG_W      = rdft_pkg::TRIG_W;
    localparam int unsigned PROD_W      = rdft_pkg::PROD_W;
    localparam int unsigned SUM_W       = rdft_pkg::SUM_W;
    localparam int unsigned BIN_IDX_W   = rdft_pkg::BIN_IDX_W;
    localparam int unsigned RES_Q_DEPTH = rdft_pkg::RES_Q_DEPTH;
    localparam int unsigned ROOM_W      = rdft_pkg::RES_CNT_W + 1;

    function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] acc,
                                                     input logic signed [PROD_W-1:0] p);
        logic [ACC_WIDTH:0] s;
        s = {acc[ACC_WIDTH-1], acc} + (ACC_WIDTH+1)'(p);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
        begin
            return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        return s[ACC_WIDTH-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] to_sum(input logic [ACC_WIDTH-1:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        return e[SUM_W-1:0];
    endfunction

    rdft_pkg::back_state_t state_reg, state_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [PHASE_W-1:0] freq_reg, freq_next;
    logic [BIN_W-1:0]   last_bin;
    logic               issue_acc, issue_dump, clr_all, room, busy;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]          time_reg;

    // accumulate pipeline
    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [BIN_W-1:0]         s1_bin_reg, s2_bin_reg, s3_bin_reg;
    logic [PHASE_W-1:0]       s1_phase_reg;
    logic signed [TRIG_W-1:0] sin_q, cos_q;
    logic signed [PROD_W-1:0] re_prod, im_prod;
    logic signed [PROD_W-1:0] s3_re_prod_reg, s3_im_prod_reg;

    // dump read in flight
    logic               dp_vld_reg;
    logic [BIN_W-1:0]   dp_bin_reg;
    logic [PHASE_W-1:0] dp_phase_reg;
    logic               dp_last_reg;

    // bin storage
    logic [MAX_BINS-1:0]  vld_reg;
    logic                 rd_vld_reg;
    logic [BIN_W-1:0]     rd_addr;
    logic [ACC_WIDTH-1:0] re_rdata, im_rdata, re_old, im_old, re_new, im_new;

    always_comb
    begin
        if (cfg.freq_intervals > NF_W'(MAX_BINS - 1))
        begin
            last_bin = BIN_W'(MAX_BINS - 1);
        end
        else
        begin
            last_bin = cfg.freq_intervals[BIN_W-1:0];
        end
    end

    // an issued dump read always finds a free result slot
    assign room = (ROOM_W'(res_count) + ROOM_W'(dp_vld_reg)) < ROOM_W'(RES_Q_DEPTH);
    assign busy = s1_vld_reg || s2_vld_reg || s3_vld_reg || dp_vld_reg;

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        freq_next  = freq_reg;
        item_pop   = 1'b0;
        issue_acc  = 1'b0;
        issue_dump = 1'b0;
        clr_all    = 1'b0;
        unique case (state_reg)
            rdft_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop  = 1'b1;
                    bin_next  = '0;
                    freq_next = cfg.phase_start;
                    unique case (item.cmd)
                        rdft_pkg::CMD_ACCUM: state_next = rdft_pkg::ST_ACCUM;
                        rdft_pkg::CMD_DUMP:  state_next = rdft_pkg::ST_DUMP;
                        rdft_pkg::CMD_CLEAR: clr_all    = 1'b1;
                        default: ;
                    endcase
                end
            end
            rdft_pkg::ST_ACCUM:
            begin
                issue_acc = 1'b1;
            end
            rdft_pkg::ST_DUMP:
            begin
                issue_dump = room;
            end
            rdft_pkg::ST_DRAIN:
            begin
                // next command waits for all writes to land
                if (!busy)
                begin
                    state_next = rdft_pkg::ST_IDLE;
                end
            end
            default: state_next = rdft_pkg::ST_IDLE;
        endcase
        if (issue_acc || issue_dump)
        begin
            if (bin_reg == last_bin)
            begin
                state_next = rdft_pkg::ST_DRAIN;
            end
            else
            begin
                bin_next  = BIN_W'(bin_reg + 1'b1);
                freq_next = freq_reg + cfg.phase_step;
            end
        end
    end

    assign rd_addr = (state_reg == rdft_pkg::ST_DUMP) ? bin_reg : s2_bin_reg;

    always_comb
    begin
        re_prod = PROD_W'(sample_reg) * PROD_W'(cos_q);
        im_prod = -(PROD_W'(sample_reg) * PROD_W'(sin_q));
        re_old  = rd_vld_reg ? re_rdata : '0;
        im_old  = rd_vld_reg ? im_rdata : '0;
        re_new  = sat_add(re_old, s3_re_prod_reg);
        im_new  = sat_add(im_old, s3_im_prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rdft_pkg::ST_IDLE;
            bin_reg    <= '0;
            freq_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            dp_vld_reg <= 1'b0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bin_reg    <= bin_next;
            freq_reg   <= freq_next;
            s1_vld_reg <= issue_acc;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            dp_vld_reg <= issue_dump;
            rd_vld_reg <= vld_reg[rd_addr];
            if (clr_all)
            begin
                vld_reg <= '0;
            end
            else if (s3_vld_reg)
            begin
                vld_reg[s3_bin_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            sample_reg <= item.sample;
            time_reg   <= item.time_index;
        end
        s1_bin_reg     <= bin_reg;
        s1_phase_reg   <= PHASE_W'(freq_reg * time_reg);
        s2_bin_reg     <= s1_bin_reg;
        s3_bin_reg     <= s2_bin_reg;
        s3_re_prod_reg <= re_prod;
        s3_im_prod_reg <= im_prod;
        dp_bin_reg     <= bin_reg;
        dp_phase_reg   <= freq_reg;
        dp_last_reg    <= (bin_reg == last_bin);
    end

    rdft_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .clk   (clk),
        .phase (s1_phase_reg),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    rdft_ram #(
        .WIDTH (ACC_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_real_sums (
        .clk   (clk),
        .we    (s3_vld_reg),
        .waddr (s3_bin_reg),
        .wdata (re_new),
        .raddr (rd_addr),
        .rdata (re_rdata)
    );

    rdft_ram #(
        .WIDTH (ACC_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_imag_sums (
        .clk   (clk),
        .we    (s3_vld_reg),
        .waddr (s3_bin_reg),
        .wdata (im_new),
        .raddr (rd_addr),
        .rdata (im_rdata)
    );

    assign res_push = dp_vld_reg;

    always_comb
    begin
        res.bin_index = BIN_IDX_W'(dp_bin_reg);
        res.bin_phase = dp_phase_reg;
        res.sum_real  = to_sum(re_old);
        res.sum_imag  = to_sum(im_old);
        res.last      = dp_last_reg;
    end

endmodule
